@@ rtl/qrrs_pkg.sv @@
// qrrs_pkg: field constants, GF(256) multiply and the generator table for the
// QR Reed-Solomon parity encoder. No dependencies.
`timescale 1ns / 1ps

package qrrs_pkg;

	localparam int MAX_ECC    = 30;
	localparam int FIELD_POLY = 285;
	localparam int CNT_W      = 5;
	localparam int N_W        = $clog2(MAX_ECC + 1);

	typedef logic [7:0] gf_t;
	typedef logic [MAX_ECC-1:0][7:0] coef_vec_t;
	typedef coef_vec_t [MAX_ECC:0] gen_table_t;
	typedef logic [N_W-1:0] count_t;

	// shift-and-add multiply, reduced by the field polynomial
	function automatic gf_t gf_mul(input gf_t a, input gf_t b);
		logic [8:0] x;
		gf_t acc;
		gf_t y;
		acc = '0;
		x   = {1'b0, a};
		y   = b;
		for (int i = 0; i < 8; i++) begin
			if (y[0]) begin
				acc = acc ^ x[7:0];
			end
			y = y >> 1;
			x = x << 1;
			if (x[8]) begin
				x = x ^ 9'(FIELD_POLY);
			end
		end
		return acc;
	endfunction

	// entry n holds g(x) without its leading 1, highest order first; the rest zero
	function automatic gen_table_t build_gen_table();
		gen_table_t tbl;
		logic [MAX_ECC:0][7:0] poly;
		gf_t root;
		tbl = '0;
		for (int n = 1; n <= MAX_ECC; n++) begin
			poly    = '0;
			poly[0] = 8'h01;
			root    = 8'h01;
			for (int i = 0; i < n; i++) begin
				for (int j = i + 1; j >= 1; j--) begin
					poly[j] = poly[j] ^ gf_mul(poly[j-1], root);
				end
				root = gf_mul(root, 8'h02);
			end
			for (int i = 0; i < n; i++) begin
				tbl[n][i] = poly[i+1];
			end
		end
		return tbl;
	endfunction

	localparam gen_table_t GEN_TABLE = build_gen_table();

endpackage

@@ rtl/qr_reed_solomon_ecc_encoder.sv @@
// qr_reed_solomon_ecc_encoder: systematic RS parity encoder over GF(256) for QR.
// Depends on qrrs_pkg (field multiply, generator table, widths).
//
//  channel | signals                       | direction | beat
//  in      | in_valid in_stall             | sink      | data_byte, last_in
//  out     | out_valid out_stall           | source    | ecc_byte, last_out
//  cfg     | cfg_valid cfg_ready           | sink      | cfg_data (ecc_count)
//
// One data beat is accepted per cycle unless stalled; it passes an input register
// and is folded into the remainder by a byte-wide LFSR with parallel GF multipliers.
// A last beat copies the remainder into a parity shift register that sends n beats,
// one per cycle unless stalled; a further last beat stalls input while it drains.
// Reset clears the remainder and the control state; cfg_ready is always high.
`timescale 1ns / 1ps

module qr_reed_solomon_ecc_encoder (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               data_byte,
	input  logic                     last_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               ecc_byte,
	output logic                     last_out,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [qrrs_pkg::CNT_W-1:0] cfg_data
);
	import qrrs_pkg::*;

	localparam int CMP_W = (CNT_W > N_W) ? CNT_W : N_W;

	logic [CNT_W-1:0] ecc_count_q;
	logic             in_block_q;
	count_t           block_n_q;
	count_t           eff_n;
	count_t           n_sel;

	logic      s1_valid_q;
	gf_t       data_s1;
	logic      last_s1;
	count_t    n_s1;

	coef_vec_t rem_q;
	coef_vec_t rem_next;
	coef_vec_t gen;
	gf_t       fb;

	coef_vec_t par_q;
	count_t    cnt_q;

	logic buf_free;
	logic s1_go;
	logic s1_load;
	logic in_acc;
	logic out_acc;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (ecc_count_q == '0) begin
			eff_n = count_t'(1);
		end else if (CMP_W'(ecc_count_q) > CMP_W'(MAX_ECC)) begin
			eff_n = count_t'(MAX_ECC);
		end else begin
			eff_n = count_t'(ecc_count_q);
		end
	end

	// a block keeps the count latched at its first beat
	assign n_sel = in_block_q ? block_n_q : eff_n;

	assign out_valid = (cnt_q != '0);
	assign ecc_byte  = par_q[0];
	assign last_out  = (cnt_q == count_t'(1));
	assign out_acc   = out_valid && !out_stall;

	assign buf_free = (cnt_q == '0) || (cnt_q == count_t'(1) && !out_stall);
	assign s1_go    = !last_s1 || buf_free;
	assign s1_load  = !s1_valid_q || s1_go;
	assign in_stall = !s1_load;
	assign in_acc   = in_valid && s1_load;

	// lfsr step; table entries above n are zero, so the upper remainder stays clear
	always_comb begin
		gen = GEN_TABLE[n_s1];
		fb  = data_s1 ^ rem_q[0];
		for (int k = 0; k < MAX_ECC - 1; k++) begin
			rem_next[k] = rem_q[k+1] ^ gf_mul(fb, gen[k]);
		end
		rem_next[MAX_ECC-1] = gf_mul(fb, gen[MAX_ECC-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_count_q <= CNT_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			ecc_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_block_q <= 1'b0;
			block_n_q  <= '0;
		end else if (in_acc) begin
			in_block_q <= !last_in;
			block_n_q  <= n_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_load) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= data_byte;
			last_s1 <= last_in;
			n_s1    <= n_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (s1_valid_q && s1_go) begin
			rem_q <= last_s1 ? coef_vec_t'('0) : rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s1_valid_q && last_s1 && buf_free) begin
			cnt_q <= n_s1;
		end else if (out_acc) begin
			cnt_q <= cnt_q - count_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && last_s1 && buf_free) begin
			par_q <= rem_next;
		end else if (out_acc) begin
			for (int k = 0; k < MAX_ECC - 1; k++) begin
				par_q[k] <= par_q[k+1];
			end
			par_q[MAX_ECC-1] <= '0;
		end
	end

endmodule
